### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands used across the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property on every rising clock edge, reset included
`define ASSERT_CLK(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/gfba_pkg.sv
// ----------------------------------------------------------------------------
// Grouped free block allocator package
// Field widths, request codes and parameter defaults.
// ----------------------------------------------------------------------------
package gfba_pkg;

   localparam int BLOCK_W            = 9;
   localparam int REQ_DATA_W         = 16;
   localparam int RSP_DATA_W         = 16;
   localparam int GROUP_SIZE_DEFAULT = 64;
   localparam int NUM_BLOCKS_DEFAULT = 512;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

endpackage

### rtl/gfba_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module gfba_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 64,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/grouped_free_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// Grouped free block allocator
// Stack of free block numbers with overflow groups chained through blocks.
// ----------------------------------------------------------------------------
// Usage: each request on the req_ channel is an allocate (tuser 0) or a
// free of tdata[8:0] (tuser 1). Exactly one response follows on rsp_:
// tdata[0] status (1 = no free block), tdata[9:1] granted block.
// One request is in work at a time; req_tready rises with the response, so
// the next request waits until the state walk below reaches the response.
// req_tready stays high while a finished response waits on rsp_.
// States from accept to response valid:
//   free onto a non-full stack, or out of range   DONE
//   allocate that leaves blocks on the stack      POP, DONE
//   free onto a full stack (group save)           BASE, SAVE, DONE
//   allocate that empties the stack (reload)      POP, BASE, LOAD, DONE
// Group save and reload go one entry a cycle through the single
// address adder and the stack RAM port; that copy makes SAVE and LOAD the long cases.
// Reset empties the stack; all memories start undefined and need no
// clearing pass. When rsp_tready is low the response holds in its output
// register and the next request is still taken, waiting at its end until
// the response register frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grouped_free_block_allocator_unit
   import gfba_pkg::*;
#(
   parameter int GROUP_SIZE = GROUP_SIZE_DEFAULT,
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // block_number[8:0], zero pad
   input  logic                  req_tuser,   // kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // status[0], granted_block[9:1], zero pad
);

   localparam int CNT_W  = $clog2(GROUP_SIZE + 1);
   localparam int SA_W   = $clog2(GROUP_SIZE);
   localparam int ADDR_W = $clog2(NUM_BLOCKS);
   localparam int GS_D   = NUM_BLOCKS * GROUP_SIZE;
   localparam int GS_AW  = $clog2(GS_D);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(GROUP_SIZE);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_POP  = 3'd1;
   localparam logic [2:0] S_BASE = 3'd2;
   localparam logic [2:0] S_SAVE = 3'd3;
   localparam logic [2:0] S_LOAD = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [BLOCK_W-1:0] blk_ff, blk_in;
   logic               kind_ff, kind_in;
   logic [GS_AW-1:0]   base_ff, base_in;
   logic               res_status_ff, res_status_in;
   logic [BLOCK_W-1:0] res_block_ff, res_block_in;
   logic               rsp_status_ff, rsp_status_in;
   logic [BLOCK_W-1:0] rsp_block_ff, rsp_block_in;

   logic [BLOCK_W-1:0] req_block;
   logic               accept;
   logic               out_free;
   logic [BLOCK_W-1:0] blk_sel;
   logic [ADDR_W+BLOCK_W-1:0] blk_wide;
   logic [ADDR_W-1:0]  blk_addr;
   logic [CNT_W-1:0]   count_dec;
   logic [CNT_W-1:0]   idx_dec;
   logic [CNT_W-1:0]   gs_off;
   logic [GS_AW-1:0]   gs_addr;
   logic [BLOCK_W-1:0] pop_block;

   logic               stk_we;
   logic [SA_W-1:0]    stk_waddr;
   logic [BLOCK_W-1:0] stk_wdata;
   logic [SA_W-1:0]    stk_raddr;
   logic [BLOCK_W-1:0] stk_rdata;
   logic               gc_we;
   logic [CNT_W-1:0]   gc_wdata;
   logic [CNT_W-1:0]   gc_rdata;
   logic               gs_we;
   logic [BLOCK_W-1:0] gs_rdata;

   assign req_block  = req_tdata[BLOCK_W-1:0];
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign blk_sel   = (state_ff == S_IDLE) ? req_block : blk_ff;
   assign blk_wide  = {{ADDR_W{1'b0}}, blk_sel};
   assign blk_addr  = blk_wide[ADDR_W-1:0];
   assign count_dec = count_ff - CNT_W'(1);
   assign idx_dec   = idx_ff - CNT_W'(1);
   assign gs_off    = (state_ff == S_SAVE) ? idx_dec : idx_ff;
   assign gs_addr   = base_ff + GS_AW'(gs_off);
   assign pop_block = (32'(stk_rdata) < NUM_BLOCKS) ? stk_rdata : '0;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      idx_in        = idx_ff;
      blk_in        = blk_ff;
      kind_in       = kind_ff;
      base_in       = base_ff;
      res_status_in = res_status_ff;
      res_block_in  = res_block_ff;
      rsp_status_in = rsp_status_ff;
      rsp_block_in  = rsp_block_ff;
      stk_we        = 1'b0;
      stk_waddr     = count_ff[SA_W-1:0];
      stk_wdata     = blk_sel;
      stk_raddr     = count_dec[SA_W-1:0];
      gc_we         = 1'b0;
      gc_wdata      = '0;
      gs_we         = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               blk_in        = req_block;
               kind_in       = req_tuser;
               res_status_in = STATUS_OK;
               res_block_in  = '0;
               state_in      = S_DONE;
               if (req_tuser == KIND_FREE) begin
                  if (32'(req_block) < NUM_BLOCKS) begin
                     if (count_ff == '0) begin
                        stk_we    = 1'b1;
                        stk_waddr = '0;
                        gc_we     = 1'b1;
                        gc_wdata  = '0;
                        count_in  = CNT_W'(1);
                     end else if (count_ff < CNT_FULL) begin
                        stk_we   = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        state_in = S_BASE;
                     end
                  end
               end else begin
                  if (count_ff == '0 || count_ff > CNT_FULL) begin
                     res_status_in = STATUS_EMPTY;
                  end else begin
                     count_in = count_dec;
                     state_in = S_POP;
                  end
               end
            end
         end
         S_POP: begin
            res_block_in = pop_block;
            blk_in       = pop_block;
            state_in     = (count_ff == '0) ? S_BASE : S_DONE;
         end
         S_BASE: begin
            base_in  = GS_AW'(blk_addr) * GS_AW'(GROUP_SIZE);
            idx_in   = '0;
            state_in = (kind_ff == KIND_FREE) ? S_SAVE : S_LOAD;
         end
         S_SAVE: begin
            stk_raddr = idx_ff[SA_W-1:0];
            gs_we     = (idx_ff != '0);
            idx_in    = idx_ff + CNT_W'(1);
            if (idx_ff == CNT_FULL) begin
               stk_we    = 1'b1;
               stk_waddr = '0;
               gc_we     = 1'b1;
               gc_wdata  = CNT_FULL;
               count_in  = CNT_W'(1);
               state_in  = S_DONE;
            end
         end
         S_LOAD: begin
            stk_we    = (idx_ff != '0);
            stk_waddr = idx_dec[SA_W-1:0];
            stk_wdata = gs_rdata;
            idx_in    = idx_ff + CNT_W'(1);
            if (idx_ff == CNT_FULL) begin
               count_in = (gc_rdata > CNT_FULL) ? CNT_FULL : gc_rdata;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_block_in  = res_block_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      blk_ff        <= blk_in;
      kind_ff       <= kind_in;
      base_ff       <= base_in;
      res_status_ff <= res_status_in;
      res_block_ff  <= res_block_in;
      rsp_status_ff <= rsp_status_in;
      rsp_block_ff  <= rsp_block_in;
   end

   gfba_ram #(
      .WIDTH(BLOCK_W),
      .DEPTH(GROUP_SIZE)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   gfba_ram #(
      .WIDTH(CNT_W),
      .DEPTH(NUM_BLOCKS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (gc_we),
      .wr_addr (blk_addr),
      .wr_data (gc_wdata),
      .rd_addr (blk_addr),
      .rd_data (gc_rdata)
   );

   gfba_ram #(
      .WIDTH(BLOCK_W),
      .DEPTH(GS_D)
   ) u_group_ram (
      .clock   (clock),
      .wr_en   (gs_we),
      .wr_addr (gs_addr),
      .wr_data (stk_rdata),
      .rd_addr (gs_addr),
      .rd_data (gs_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - BLOCK_W - 1){1'b0}}, rsp_block_ff, rsp_status_ff};

   `ASSERT_CLK_RST(a_count_bound, clock, reset, count_ff <= CNT_FULL,
      "stack count above group size")
   `ASSERT_CLK_RST(a_copy_bound, clock, reset,
      (state_ff == S_SAVE || state_ff == S_LOAD) |-> idx_ff <= CNT_FULL,
      "group copy index overran")
   `ASSERT_CLK_RST(a_empty_grant, clock, reset,
      (rsp_valid_ff && rsp_status_ff == STATUS_EMPTY) |-> rsp_block_ff == '0,
      "failed allocate granted a block")
   `ASSERT_CLK_RST(a_busy_stall, clock, reset,
      (state_ff == S_DONE && !out_free) |=> state_ff == S_DONE,
      "response issued over a pending one")

endmodule
